[design/max_priority_queue_unsorted_defines.svh]
// assertion macros for the unsorted max priority queue
// no dependencies; included by modules that carry checks
`ifndef MAX_PRIORITY_QUEUE_UNSORTED_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_UNSORTED_DEFINES_SVH
`ifndef SYNTHESIS
`define MPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mpq check failed");
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mpq check failed");
`else
`define MPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/mpq_pkg.sv]
// shared types for the unsorted max priority queue
// no dependencies
package mpq_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic start_scan;
        logic scan_run;
        logic start_shift;
        logic shift_run;
        logic dec_occ;
        logic out_load;
    } t_ctrl;

    typedef struct packed {
        logic req_scan;
        logic is_remove;
        logic scan_last;
        logic shift_end;
        logic out_free;
    } t_stat;

endpackage

[design/mpq_ram.sv]
// generic single write, single read RAM with registered read data
// no dependencies
module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[design/mpq_ctrl.sv]
// request sequencer: accept, scan, pick, shift, deliver
// depends on mpq_pkg
module mpq_ctrl import mpq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.req_scan ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                n_state = i_stat.is_remove ? S_SHIFT : S_DONE;
            end
            S_SHIFT: begin
                if (i_stat.shift_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready         = (r_state == S_IDLE);
        o_ctrl.accept      = o_in_ready && i_in_valid;
        o_ctrl.start_scan  = o_ctrl.accept && i_stat.req_scan;
        o_ctrl.scan_run    = (r_state == S_SCAN);
        o_ctrl.start_shift = (r_state == S_PICK) && i_stat.is_remove;
        o_ctrl.shift_run   = (r_state == S_SHIFT);
        o_ctrl.dec_occ     = (r_state == S_SHIFT) && i_stat.shift_end;
        o_ctrl.out_load    = (r_state == S_DONE) && i_stat.out_free;
    end

endmodule

[design/mpq_dpath.sv]
// store, occupancy, max scan, gap shift and output word register
// depends on mpq_pkg, mpq_ram and the assertion macro header
`include "max_priority_queue_unsorted_defines.svh"
module mpq_dpath import mpq_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_value,
    input  t_ctrl              i_ctrl,
    output t_stat              o_stat,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [31:0] o_max_value,
    output logic [1:0]         o_status,
    output logic [5:0]         o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_occ;
    logic [CW-1:0] r_ridx;
    logic          r_pend;
    logic [AW-1:0] r_didx;
    logic          r_have;
    logic [31:0]   r_best;
    logic [AW-1:0] r_bidx;
    t_cmd          r_cmd;
    t_status       r_stat;
    logic          r_ovalid;

    t_cmd          w_cmd;
    logic          w_empty;
    logic          w_full;
    logic          w_run;
    logic          w_more;
    logic          w_issue;
    logic          w_ins;
    logic          w_shift_wr;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata;
    logic [AW-1:0] w_raddr;
    logic [31:0]   w_rdata;
    logic          w_take;
    logic          w_out_free;
    logic [CW+5:0] w_cnt_ext;
    t_status       w_new_stat;

    assign w_cmd      = t_cmd'(i_cmd);
    assign w_empty    = (r_occ == '0);
    assign w_full     = (r_occ == CW'(CAPACITY));
    assign w_run      = i_ctrl.scan_run || i_ctrl.shift_run;
    assign w_more     = (r_ridx < r_occ);
    assign w_issue    = w_run && w_more;
    assign w_ins      = i_ctrl.accept && (w_cmd == CMD_INSERT) && !w_full;
    assign w_shift_wr = i_ctrl.shift_run && r_pend;
    assign w_take     = !r_have || ($signed(r_best) < $signed(w_rdata));
    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_cnt_ext  = {6'b0, r_occ};

    always_comb begin
        unique case (w_cmd)
            CMD_INSERT: w_new_stat = w_full ? ST_FULL : ST_OK;
            CMD_REMOVE,
            CMD_FIND:   w_new_stat = w_empty ? ST_EMPTY : ST_OK;
            default:    w_new_stat = ST_OK;
        endcase
    end

    always_comb begin
        w_we    = w_ins || w_shift_wr;
        w_waddr = w_ins ? r_occ[AW-1:0] : (r_didx - AW'(1));
        w_wdata = w_ins ? i_value : w_rdata;
        w_raddr = i_ctrl.start_scan ? '0 : r_ridx[AW-1:0];
    end

    mpq_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_ins) begin
                r_occ <= r_occ + CW'(1);
            end else if (i_ctrl.dec_occ) begin
                r_occ <= r_occ - CW'(1);
            end
            priority if (i_ctrl.start_scan) begin
                r_pend <= 1'b1;
            end else if (i_ctrl.start_shift) begin
                r_pend <= 1'b0;
            end else begin
                r_pend <= w_issue;
            end
            if (i_ctrl.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_cmd  <= w_cmd;
            r_stat <= w_new_stat;
        end
        priority if (i_ctrl.start_scan) begin
            r_ridx <= CW'(1);
            r_didx <= '0;
        end else if (i_ctrl.start_shift) begin
            r_ridx <= CW'(r_bidx) + CW'(1);
        end else if (w_issue) begin
            r_ridx <= r_ridx + CW'(1);
            r_didx <= r_ridx[AW-1:0];
        end
        if (i_ctrl.start_scan) begin
            r_have <= 1'b0;
        end else if (i_ctrl.scan_run && r_pend) begin
            r_have <= 1'b1;
            if (w_take) begin
                r_best <= w_rdata;
                r_bidx <= r_didx;
            end
        end
        if (i_ctrl.out_load) begin
            o_max_value <= ((r_stat == ST_OK) &&
                            ((r_cmd == CMD_REMOVE) || (r_cmd == CMD_FIND))) ?
                           $signed(r_best) : '0;
            o_status    <= r_stat;
            o_count     <= w_cnt_ext[5:0];
        end
    end

    always_comb begin
        o_stat.req_scan  = ((w_cmd == CMD_REMOVE) || (w_cmd == CMD_FIND)) && !w_empty;
        o_stat.is_remove = (r_cmd == CMD_REMOVE);
        o_stat.scan_last = r_pend && !w_more;
        o_stat.shift_end = !r_pend && !w_more;
        o_stat.out_free  = w_out_free;
    end

    assign o_out_valid = r_ovalid;

    `MPQ_ASSERT_IMPL(a_occ_bound, i_clk, i_rst_n, 1'b1, r_occ <= CW'(CAPACITY))
    `MPQ_ASSERT_IMPL(a_shift_in_store, i_clk, i_rst_n, w_shift_wr,
                     (CW'(r_didx) < r_occ) && (r_didx != '0))
    `MPQ_ASSERT_NEXT(a_dec_one, i_clk, i_rst_n, i_ctrl.dec_occ,
                     r_occ == $past(r_occ) - CW'(1))
    `MPQ_ASSERT_IMPL(a_no_write_clash, i_clk, i_rst_n, w_ins, !w_shift_wr)

endmodule

[design/max_priority_queue_unsorted.sv]
// channel     direction  handshake                  payload
// request     in         i_in_valid / o_in_ready    i_cmd, i_value
// result      out        o_out_valid / i_out_ready  o_max_value, o_status, o_count
//
// one request at a time; the store is a single-port-write RAM walked one entry a cycle
// insert and any rejected request: no scan; the done state loads the word after accept
// find on n entries: the scan reads all n entries, then pick, then done loads the word
// remove: as find, plus a shift moving the m entries above the maximum down one place
// synchronous active-low reset empties the queue; entries are undefined until written
// a stalled result holds in the output register while the next request is accepted
module max_priority_queue_unsorted import mpq_pkg::*; #(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_max_value,
    output logic [1:0]         o_status,
    output logic [5:0]         o_count
);

    t_ctrl w_ctrl;
    t_stat w_stat;

    mpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_stat    (w_stat),
        .o_ctrl    (w_ctrl)
    );

    mpq_dpath #(
        .CAPACITY(CAPACITY)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_value    (i_value),
        .i_ctrl     (w_ctrl),
        .o_stat     (w_stat),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_max_value(o_max_value),
        .o_status   (o_status),
        .o_count    (o_count)
    );

endmodule
